FILE: rtl/rsr_pkg.sv
package rsr_pkg;

    // Result width and divider geometry
    localparam int STAT_W    = 64;
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 6;

    // Register map
    localparam int KIND_W   = 4;
    localparam int REG_KIND = 0;

    // Statistic selector codes
    typedef enum logic [KIND_W-1:0] {
        KIND_COUNT     = 4'd0,
        KIND_SUM       = 4'd1,
        KIND_FIRST     = 4'd2,
        KIND_LAST      = 4'd3,
        KIND_MIN       = 4'd4,
        KIND_AVERAGE   = 4'd5,
        KIND_MAX       = 4'd6,
        KIND_PERIOD_AVG = 4'd7,
        KIND_INCREASE  = 4'd8
    } kind_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SEL  = 2'd1,
        BK_DIV  = 2'd2
    } bk_state_t;

    // Divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: rtl/rsr_front.sv
module rsr_front #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int TDATA_W      = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_W-1:0]      s_tdata,
    input  logic                    s_tuser,
    output logic                    q_valid,
    output logic                    q_clear,
    output logic [SAMPLE_WIDTH-1:0] q_sample,
    input  logic                    q_pop
);

    // Two-entry command queue: clear flag and sample per entry
    logic                    clear_reg  [2];
    logic [SAMPLE_WIDTH-1:0] sample_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              fill_reg, fill_next;
    logic                    push;

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_clear  = clear_reg[rd_ptr_reg];
    assign q_sample = sample_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && q_pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Classify the beat on entry: clear items drop their sample
    always_ff @(posedge aclk) begin
        if (push) begin
            clear_reg[wr_ptr_reg]  <= s_tuser;
            sample_reg[wr_ptr_reg] <= s_tuser ? '0 : s_tdata[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

FILE: rtl/rsr_div.sv
module rsr_div #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rsr_pkg::STAT_W-1:0]  dividend,
    input  logic [COUNT_WIDTH-1:0]      divisor,
    output logic [rsr_pkg::STAT_W-1:0]  quotient,
    output rsr_pkg::div_status_t        status
);

    logic [rsr_pkg::STAT_W-1:0]   quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0]       rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]       dvs_reg;
    logic [rsr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [COUNT_WIDTH:0]         trial;
    logic [COUNT_WIDTH:0]         diff;

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // One restoring step per cycle, quotient bits shift in at the bottom
    always_comb begin
        trial     = {rem_reg, quo_reg[rsr_pkg::STAT_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = rsr_pkg::DIV_CNT_W'(rsr_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[COUNT_WIDTH]) begin
                rem_next = diff[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[rsr_pkg::STAT_W-2:0], 1'b1};
            end else begin
                rem_next = trial[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[rsr_pkg::STAT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

endmodule

FILE: rtl/rsr_back.sv
module rsr_back #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rsr_pkg::kind_t             kind,
    input  logic                       q_valid,
    input  logic                       q_clear,
    input  logic [SAMPLE_WIDTH-1:0]    q_sample,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rsr_pkg::STAT_W-1:0] m_tdata
);

    localparam int SW = rsr_pkg::STAT_W;

    rsr_pkg::bk_state_t state_reg, state_next;

    // Running totals
    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [SW-1:0]                  sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] first_reg, last_reg, least_reg, greatest_reg;
    logic signed [SAMPLE_WIDTH-1:0] smp;

    // Output slot and divider hookup
    logic                 m_valid_reg;
    logic [SW-1:0]        m_data_reg;
    logic                 out_load;
    logic [SW-1:0]        out_value;
    logic                 neg_reg;
    logic                 div_start;
    logic [SW-1:0]        div_quo;
    rsr_pkg::div_status_t div_st;
    logic [SW-1:0]        sum_mag;
    logic [SW-1:0]        stat;
    logic                 is_avg;

    assign smp      = q_sample;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign sum_mag  = sum_reg[SW-1] ? (SW'(0) - sum_reg) : sum_reg;
    assign is_avg   = (kind == rsr_pkg::KIND_AVERAGE) || (kind == rsr_pkg::KIND_PERIOD_AVG);

    rsr_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .quotient (div_quo),
        .status   (div_st)
    );

    // Selected statistic from the settled totals
    always_comb begin
        case (kind)
            rsr_pkg::KIND_COUNT:    stat = SW'(count_reg);
            rsr_pkg::KIND_SUM:      stat = sum_reg;
            rsr_pkg::KIND_FIRST:    stat = SW'(first_reg);
            rsr_pkg::KIND_LAST:     stat = SW'(last_reg);
            rsr_pkg::KIND_MIN:      stat = SW'(least_reg);
            rsr_pkg::KIND_MAX:      stat = SW'(greatest_reg);
            rsr_pkg::KIND_INCREASE: stat = SW'(last_reg) - SW'(first_reg);
            default:                stat = '0;
        endcase
    end

    // Sequencer: pop, settle totals, then select or divide
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        out_value  = stat;
        case (state_reg)
            rsr_pkg::BK_IDLE: begin
                if (q_valid && !m_valid_reg) begin
                    q_pop      = 1'b1;
                    state_next = rsr_pkg::BK_SEL;
                end
            end
            rsr_pkg::BK_SEL: begin
                if (is_avg && (count_reg != '0)) begin
                    div_start  = 1'b1;
                    state_next = rsr_pkg::BK_DIV;
                end else begin
                    out_load   = 1'b1;
                    state_next = rsr_pkg::BK_IDLE;
                end
            end
            rsr_pkg::BK_DIV: begin
                out_value = neg_reg ? (SW'(0) - div_quo) : div_quo;
                if (div_st.done) begin
                    out_load   = 1'b1;
                    state_next = rsr_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = rsr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsr_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Fold a sample or clear the totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            least_reg    <= '0;
            greatest_reg <= '0;
        end else if (q_pop) begin
            if (q_clear) begin
                count_reg    <= '0;
                sum_reg      <= '0;
                first_reg    <= '0;
                last_reg     <= '0;
                least_reg    <= '0;
                greatest_reg <= '0;
            end else begin
                if (count_reg == '0) begin
                    first_reg    <= smp;
                    least_reg    <= smp;
                    greatest_reg <= smp;
                end else begin
                    if (smp < least_reg) begin
                        least_reg <= smp;
                    end
                    if (smp > greatest_reg) begin
                        greatest_reg <= smp;
                    end
                end
                sum_reg  <= sum_reg + SW'(smp);
                last_reg <= smp;
                if (count_reg != '1) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Sign of the sum, held while dividing
    always_ff @(posedge aclk) begin
        if (div_start) begin
            neg_reg <= sum_reg[SW-1];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_value;
        end
    end

endmodule

FILE: rtl/running_stats_reducer.sv
// Running statistics over signed samples.
// Input beats (s_*): tuser is the action (1 clears all totals, 0 folds the
// sample in tdata). Every input beat yields exactly one output beat (m_*)
// carrying the 64-bit statistic chosen by the reduction_kind register,
// computed from the totals after that beat.
// reduction_kind sits at APB byte address 0; write it only while idle.
// After an item is popped, m_tvalid rises once its statistic is loaded into
// the output register; for average / period average with a nonzero count the
// divider is loaded first and runs 64 one-bit restoring steps, then the
// quotient is registered at the output.
// One item is worked on at a time; the next one is popped the cycle after the
// output beat is taken.
// A two-entry queue behind the input takes further beats while an item is
// being worked on or a result waits on m_tready; when the output beat stalls
// the back end holds and the queue fills, then s_tready drops.
// Synchronous reset (aresetn low) zeroes all totals, clears the queue and
// m_tvalid, and sets reduction_kind to count.
module running_stats_reducer #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic                                 s_tuser,   // [0] action
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rsr_pkg::STAT_W-1:0]           m_tdata,   // [63:0] statistic
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    rsr_pkg::kind_t          kind_reg;
    logic                    cfg_hit;
    logic                    q_valid;
    logic                    q_clear;
    logic [SAMPLE_WIDTH-1:0] q_sample;
    logic                    q_pop;

    // Register file: one 4-bit selector
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == 1'b0);
    assign prdata  = cfg_hit ? 32'(kind_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= rsr_pkg::KIND_COUNT;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            kind_reg <= rsr_pkg::kind_t'(pwdata[rsr_pkg::KIND_W-1:0]);
        end
    end

    rsr_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_clear  (q_clear),
        .q_sample (q_sample),
        .q_pop    (q_pop)
    );

    rsr_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .kind     (kind_reg),
        .q_valid  (q_valid),
        .q_clear  (q_clear),
        .q_sample (q_sample),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
